FILE: src/cmap_pkg.sv
// shared constants and types for the pixel colormap core
package cmap_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned RGB_W         = 3 * CH_W;
  localparam int unsigned PIX_W         = 32;
  localparam int unsigned DIFF_W        = PIX_W + 1;
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned Q_W           = 16;
  localparam int unsigned NUM_W         = DIFF_W + Q_W;
  localparam int unsigned WGT_W         = FRAC_W + 1;
  localparam int unsigned MIX_W         = CH_W + FRAC_W;

  localparam logic [IDX_W-1:0]  TOP_ENTRY  = 8'hFF;
  localparam logic [WGT_W-1:0]  WEIGHT_ONE = 9'd256;

  localparam logic              KIND_LOAD  = 1'b0;

  localparam int unsigned       CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAREST    = 2'd2;

  localparam logic signed [PIX_W-1:0] RANGE_LOW_RST  = 32'sd0;
  localparam logic signed [PIX_W-1:0] RANGE_HIGH_RST = 32'sd255;

  // sideband that travels with every item down the pipeline
  typedef struct packed {
    logic             vld;
    logic             load;
    logic [IDX_W-1:0] entry_index;
    logic [RGB_W-1:0] entry_rgb;
    logic             flat;
    logic             flat_hi;
    logic             neg;
    logic             ovf;
  } cmap_side_t;

endpackage

FILE: src/cmap_ram.sv
// generic ram, one write port and two registered read ports
module cmap_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/cmap_prescale.sv
// front stages: offset, magnitude, scale by 65280 and range check
module cmap_prescale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  accept,
  input  logic                                  kind,
  input  logic [cmap_pkg::IDX_W-1:0]            entry_index,
  input  logic [cmap_pkg::RGB_W-1:0]            entry_rgb,
  input  logic signed [cmap_pkg::PIX_W-1:0]     pixel,
  input  logic signed [cmap_pkg::PIX_W-1:0]     range_low,
  input  logic signed [cmap_pkg::PIX_W-1:0]     range_high,
  input  logic [cmap_pkg::DIFF_W-1:0]           w_abs,
  input  logic                                  w_neg,
  output cmap_pkg::cmap_side_t                  side_o,
  output logic [cmap_pkg::DIFF_W-1:0]           rem_o,
  output logic [cmap_pkg::Q_W-1:0]              low_o
);

  cmap_pkg::cmap_side_t              s0_side, s1_side, s2_side;
  cmap_pkg::cmap_side_t              s0_side_next, s1_side_next, s2_side_next;
  logic [cmap_pkg::DIFF_W-1:0]       s0_diff, s0_diff_next;
  logic [cmap_pkg::DIFF_W-1:0]       d_abs;
  logic [cmap_pkg::NUM_W-1:0]        s1_num, s1_num_next;
  logic                              s1_neg_next;
  logic                              s2_ovf_next;
  logic [cmap_pkg::DIFF_W-1:0]       s2_rem;
  logic [cmap_pkg::Q_W-1:0]          s2_low;

  always_comb begin
    s0_side_next             = '0;
    s0_side_next.vld         = accept;
    s0_side_next.load        = (kind == cmap_pkg::KIND_LOAD);
    s0_side_next.entry_index = entry_index;
    s0_side_next.entry_rgb   = entry_rgb;
    s0_side_next.flat        = (range_low == range_high);
    s0_side_next.flat_hi     = (pixel > range_high);
    s0_diff_next = {pixel[cmap_pkg::PIX_W-1], pixel}
                 - {range_low[cmap_pkg::PIX_W-1], range_low};
  end

  // |d| * 65280 as |d| * 2^16 - |d| * 2^8
  always_comb begin
    d_abs = s0_diff[cmap_pkg::DIFF_W-1] ? (~s0_diff + 1'b1) : s0_diff;
    s1_num_next = {d_abs, {cmap_pkg::Q_W{1'b0}}}
                - {{cmap_pkg::FRAC_W{1'b0}}, d_abs, {cmap_pkg::FRAC_W{1'b0}}};
    s1_neg_next = s0_diff[cmap_pkg::DIFF_W-1] ^ w_neg;
    s1_side_next     = s0_side;
    s1_side_next.neg = s1_neg_next;
  end

  // quotient of 2^16 or more saturates the table position
  always_comb begin
    s2_ovf_next      = (s1_num >= {w_abs, {cmap_pkg::Q_W{1'b0}}});
    s2_side_next     = s1_side;
    s2_side_next.ovf = s2_ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side.vld <= 1'b0;
      s1_side.vld <= 1'b0;
      s2_side.vld <= 1'b0;
    end else if (en) begin
      s0_side      <= s0_side_next;
      s0_diff      <= s0_diff_next;
      s1_side      <= s1_side_next;
      s1_num       <= s1_num_next;
      s2_side      <= s2_side_next;
      s2_rem       <= s1_num[cmap_pkg::NUM_W-1:cmap_pkg::Q_W];
      s2_low       <= s1_num[cmap_pkg::Q_W-1:0];
    end
  end

  assign side_o = s2_side;
  assign rem_o  = s2_rem;
  assign low_o  = s2_low;

endmodule

FILE: src/cmap_div.sv
// restoring divider, one quotient bit per pipeline stage
module cmap_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [cmap_pkg::DIFF_W-1:0]       w_abs,
  input  cmap_pkg::cmap_side_t              side_i,
  input  logic [cmap_pkg::DIFF_W-1:0]       rem_i,
  input  logic [cmap_pkg::Q_W-1:0]          low_i,
  output cmap_pkg::cmap_side_t              side_o,
  output logic [cmap_pkg::Q_W-1:0]          quot_o
);

  cmap_pkg::cmap_side_t        st_side [cmap_pkg::Q_W+1];
  logic [cmap_pkg::DIFF_W-1:0] st_rem  [cmap_pkg::Q_W+1];
  logic [cmap_pkg::Q_W-1:0]    st_low  [cmap_pkg::Q_W+1];

  assign st_side[0] = side_i;
  assign st_rem[0]  = rem_i;
  assign st_low[0]  = low_i;

  for (genvar k = 0; k < cmap_pkg::Q_W; k++) begin : g_step
    cmap_pkg::cmap_side_t        side_q;
    logic [cmap_pkg::DIFF_W-1:0] rem_q;
    logic [cmap_pkg::Q_W-1:0]    low_q;
    logic [cmap_pkg::DIFF_W:0]   shifted;
    logic [cmap_pkg::DIFF_W:0]   trial;
    logic                        fits;

    // low word shifts out at the top while quotient bits enter at the bottom
    assign shifted = {st_rem[k], st_low[k][cmap_pkg::Q_W-1]};
    assign trial   = shifted - {1'b0, w_abs};
    assign fits    = ~trial[cmap_pkg::DIFF_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q.vld <= 1'b0;
      end else if (en) begin
        side_q <= st_side[k];
        rem_q  <= fits ? trial[cmap_pkg::DIFF_W-1:0] : shifted[cmap_pkg::DIFF_W-1:0];
        low_q  <= {st_low[k][cmap_pkg::Q_W-2:0], fits};
      end
    end

    assign st_side[k+1] = side_q;
    assign st_rem[k+1]  = rem_q;
    assign st_low[k+1]  = low_q;
  end

  assign side_o = st_side[cmap_pkg::Q_W];
  assign quot_o = st_low[cmap_pkg::Q_W];

endmodule

FILE: src/cmap_lookup.sv
// index select, colour table read and linear blend
module cmap_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          nearest,
  input  cmap_pkg::cmap_side_t          side_i,
  input  logic [cmap_pkg::Q_W-1:0]      quot_i,
  output logic                          res_vld,
  output logic [cmap_pkg::RGB_W-1:0]    res_rgb
);

  logic [cmap_pkg::IDX_W-1:0]    idx_next, frac_next;
  cmap_pkg::cmap_side_t          x_side, t_side;
  logic [cmap_pkg::IDX_W-1:0]    x_idx, x_nxt, x_frac;
  logic [cmap_pkg::IDX_W-1:0]    t_idx, t_nxt, t_frac;
  logic                          t_hit_a, t_hit_b;
  logic [cmap_pkg::TABLE_ENTRIES-1:0] written;
  logic                          tab_we;
  logic [cmap_pkg::RGB_W-1:0]    rd_a, rd_b, ent_a, ent_b, blended;
  logic [cmap_pkg::WGT_W-1:0]    wgt_a;
  logic [cmap_pkg::MIX_W-1:0]    mix;

  always_comb begin
    if (side_i.neg) begin
      idx_next  = '0;
      frac_next = '0;
    end else if (side_i.ovf || quot_i[cmap_pkg::Q_W-1:cmap_pkg::FRAC_W] == cmap_pkg::TOP_ENTRY) begin
      idx_next  = cmap_pkg::TOP_ENTRY;
      frac_next = '0;
    end else begin
      idx_next  = quot_i[cmap_pkg::Q_W-1:cmap_pkg::FRAC_W];
      frac_next = nearest ? '0 : quot_i[cmap_pkg::FRAC_W-1:0];
    end
  end

  // loads write at the same stage that converts read, so order is kept
  assign tab_we = en && x_side.vld && x_side.load;

  cmap_ram #(
    .WIDTH (cmap_pkg::RGB_W),
    .DEPTH (cmap_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (x_side.entry_index),
    .wdata   (x_side.entry_rgb),
    .re      (en),
    .raddr_a (x_idx),
    .raddr_b (x_nxt),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // entries never loaded read as the grey ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (tab_we) begin
      written[x_side.entry_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_side.vld <= 1'b0;
      t_side.vld <= 1'b0;
    end else if (en) begin
      x_side  <= side_i;
      x_idx   <= idx_next;
      x_nxt   <= idx_next + 1'b1;
      x_frac  <= frac_next;
      t_side  <= x_side;
      t_idx   <= x_idx;
      t_nxt   <= x_nxt;
      t_frac  <= x_frac;
      t_hit_a <= written[x_idx];
      t_hit_b <= written[x_nxt];
    end
  end

  assign ent_a = t_hit_a ? rd_a : {3{t_idx}};
  assign ent_b = t_hit_b ? rd_b : {3{t_nxt}};
  assign wgt_a = cmap_pkg::WEIGHT_ONE - {1'b0, t_frac};

  always_comb begin
    blended = '0;
    mix     = '0;
    for (int c = 0; c < 3; c++) begin
      mix = cmap_pkg::MIX_W'(ent_a[c*cmap_pkg::CH_W +: cmap_pkg::CH_W] * wgt_a)
          + cmap_pkg::MIX_W'(ent_b[c*cmap_pkg::CH_W +: cmap_pkg::CH_W] * t_frac);
      blended[c*cmap_pkg::CH_W +: cmap_pkg::CH_W] = mix[cmap_pkg::MIX_W-1:cmap_pkg::FRAC_W];
    end
  end

  assign res_vld = t_side.vld && !t_side.load;
  assign res_rgb = t_side.flat ? {cmap_pkg::RGB_W{t_side.flat_hi}} : blended;

  a_frac_below_top: assert property (@(posedge clk) disable iff (rst)
    (x_side.vld && !x_side.load && x_frac != '0) |-> (x_idx != cmap_pkg::TOP_ENTRY))
    else $error("blend fraction set at the top entry");

  a_load_marks_entry: assert property (@(posedge clk) disable iff (rst)
    tab_we |=> written[$past(x_side.entry_index)])
    else $error("loaded entry not marked as written");

endmodule

FILE: src/pixel_lut_colormap_core.sv
// top level of the pixel colormap core: registers, pipeline and output skid
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  item     | item_valid / item_stall   | kind, entry_index, entry_*, pixel
//  result   | result_valid / result_stall | red, green, blue
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one item accepted per cycle while item_stall is low; a result reaches the output register
// after its item passes the prescale stages, the 16-stage restoring divider and the lookup stages.
// synchronous reset restores the range registers, nearest mode and the grey ramp.
// a held result parks a second one in the skid register; item_stall follows it.
// load items pass the pipeline in order and give no result.
module pixel_lut_colormap_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  kind,
  input  logic [cmap_pkg::IDX_W-1:0]            entry_index,
  input  logic [cmap_pkg::CH_W-1:0]             entry_red,
  input  logic [cmap_pkg::CH_W-1:0]             entry_green,
  input  logic [cmap_pkg::CH_W-1:0]             entry_blue,
  input  logic signed [cmap_pkg::PIX_W-1:0]     pixel,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [cmap_pkg::CH_W-1:0]             red,
  output logic [cmap_pkg::CH_W-1:0]             green,
  output logic [cmap_pkg::CH_W-1:0]             blue,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cmap_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmap_pkg::PIX_W-1:0]            cfg_data
);

  logic signed [cmap_pkg::PIX_W-1:0] range_low, range_high;
  logic                              nearest_mode;
  logic [cmap_pkg::DIFF_W-1:0]       w_span, w_abs;
  logic                              w_neg;
  logic                              en, item_accept, result_take;
  cmap_pkg::cmap_side_t              pre_side, div_side;
  logic [cmap_pkg::DIFF_W-1:0]       pre_rem;
  logic [cmap_pkg::Q_W-1:0]          pre_low, div_quot;
  logic                              pipe_vld;
  logic [cmap_pkg::RGB_W-1:0]        pipe_rgb, out_rgb, skid_rgb;
  logic                              skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low    <= cmap_pkg::RANGE_LOW_RST;
      range_high   <= cmap_pkg::RANGE_HIGH_RST;
      nearest_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmap_pkg::REG_RANGE_LOW:  range_low    <= cfg_data;
        cmap_pkg::REG_RANGE_HIGH: range_high   <= cfg_data;
        cmap_pkg::REG_NEAREST:    nearest_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divisor magnitude and sign; the user keeps them steady while items flow (not enforced)
  assign w_span = {range_high[cmap_pkg::PIX_W-1], range_high}
                - {range_low[cmap_pkg::PIX_W-1], range_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      w_abs <= cmap_pkg::DIFF_W'(cmap_pkg::RANGE_HIGH_RST);
      w_neg <= 1'b0;
    end else begin
      w_abs <= w_span[cmap_pkg::DIFF_W-1] ? (~w_span + 1'b1) : w_span;
      w_neg <= w_span[cmap_pkg::DIFF_W-1];
    end
  end

  assign en          = !skid_valid;
  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  cmap_prescale u_prescale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .accept      (item_accept),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_rgb   ({entry_red, entry_green, entry_blue}),
    .pixel       (pixel),
    .range_low   (range_low),
    .range_high  (range_high),
    .w_abs       (w_abs),
    .w_neg       (w_neg),
    .side_o      (pre_side),
    .rem_o       (pre_rem),
    .low_o       (pre_low)
  );

  cmap_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .w_abs  (w_abs),
    .side_i (pre_side),
    .rem_i  (pre_rem),
    .low_i  (pre_low),
    .side_o (div_side),
    .quot_o (div_quot)
  );

  cmap_lookup u_lookup (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .nearest (nearest_mode),
    .side_i  (div_side),
    .quot_i  (div_quot),
    .res_vld (pipe_vld),
    .res_rgb (pipe_rgb)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        out_rgb    <= skid_rgb;
        skid_valid <= 1'b0;
      end
    end else if (pipe_vld) begin
      if (!result_valid || result_take) begin
        out_rgb      <= pipe_rgb;
        result_valid <= 1'b1;
      end else begin
        skid_rgb   <= pipe_rgb;
        skid_valid <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  assign red   = out_rgb[2*cmap_pkg::CH_W +: cmap_pkg::CH_W];
  assign green = out_rgb[cmap_pkg::CH_W +: cmap_pkg::CH_W];
  assign blue  = out_rgb[0 +: cmap_pkg::CH_W];

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid filled without a held result");

endmodule

FILE: verif/pixel_lut_colormap_core_test.sv
// self-checking testbench for the pixel colormap core: directed rows, then random items
module pixel_lut_colormap_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_PIXEL = ~cmap_pkg::KIND_LOAD;
  localparam logic [cmap_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint               PIX_MIN        = -64'sd2147483648;
  localparam longint               PIX_MAX        = 64'sd2147483647;
  localparam longint               FULL_SCALE_Q   = 255 * 256;
  localparam int                   HOLD_OFF       = 30;
  // pipeline drain plus stall runs plus the hold-off, with a wide margin
  localparam int                   WATCHDOG_LIMIT = 3000;
  localparam int                   RANDOM_ITEMS   = 1825;

  typedef struct packed {
    logic [cmap_pkg::CH_W-1:0] r;
    logic [cmap_pkg::CH_W-1:0] g;
    logic [cmap_pkg::CH_W-1:0] b;
  } colour_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_LOAD, ROW_SETUP} row_op_t;

  typedef struct packed {
    row_op_t                    op;
    logic [7:0]                 sel;    // entry index or register index
    logic [cmap_pkg::RGB_W-1:0] rgb;
    logic [cmap_pkg::PIX_W-1:0] val;    // pixel or register data
    logic                       typed;
    logic [cmap_pkg::RGB_W-1:0] want;
  } plan_row_t;

  localparam plan_row_t PLAN [0:33] = '{
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0000, 1'b1, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_00FF, 1'b1, 24'hFFFFFF},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0064, 1'b1, 24'h646464},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h8000_0000, 1'b1, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h7FFF_FFFF, 1'b1, 24'hFFFFFF},
    '{ROW_LOAD,  8'd0,   24'hFF0000, 32'h7FFF_FFFF, 1'b0, 24'h000000},
    '{ROW_LOAD,  8'd255, 24'h00FFFF, 32'h8000_0000, 1'b0, 24'h000000},
    '{ROW_LOAD,  8'd128, 24'hAA55FF, 32'h0000_0000, 1'b0, 24'h000000},
    '{ROW_LOAD,  8'd1,   24'h55AA00, 32'hFFFF_FFFF, 1'b0, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'hFFFF_FFFB, 1'b1, 24'hFF0000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_012C, 1'b1, 24'h00FFFF},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0080, 1'b1, 24'hAA55FF},
    // empty range
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_LOW),  24'h0, 32'h0000_0005, 1'b0, 24'h0},
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_HIGH), 24'h0, 32'h0000_0005, 1'b0, 24'h0},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0006, 1'b1, 24'hFFFFFF},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0005, 1'b1, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h8000_0000, 1'b1, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h7FFF_FFFF, 1'b1, 24'hFFFFFF},
    // interpolation over a range twice the table
    '{ROW_SETUP, 8'(cmap_pkg::REG_NEAREST),    24'h0, 32'hFFFF_FFFE, 1'b0, 24'h0},
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_LOW),  24'h0, 32'h0000_0000, 1'b0, 24'h0},
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_HIGH), 24'h0, 32'h0000_01FE, 1'b0, 24'h0},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0001, 1'b0, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_00FF, 1'b0, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0000, 1'b1, 24'hFF0000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_01FE, 1'b1, 24'h00FFFF},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h7FFF_FFFF, 1'b1, 24'h00FFFF},
    // reversed range at the extremes
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_LOW),  24'h0, 32'h7FFF_FFFF, 1'b0, 24'h0},
    '{ROW_SETUP, 8'(cmap_pkg::REG_RANGE_HIGH), 24'h0, 32'h8000_0000, 1'b0, 24'h0},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h8000_0000, 1'b0, 24'h000000},
    '{ROW_SETUP, 8'(REG_UNUSED),               24'h0, 32'hA5A5_5A5A, 1'b0, 24'h0},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h7FFF_FFFF, 1'b0, 24'h000000},
    '{ROW_SETUP, 8'(cmap_pkg::REG_NEAREST),    24'h0, 32'h0000_0001, 1'b0, 24'h0},
    '{ROW_PIXEL, 8'd0,   24'h000000, 32'h0000_0000, 1'b0, 24'h000000}
  };

  logic                              clk;
  logic                              rst          = 1'b1;
  logic                              item_valid   = 1'b0;
  logic                              item_stall;
  logic                              kind         = cmap_pkg::KIND_LOAD;
  logic [cmap_pkg::IDX_W-1:0]        entry_index  = '0;
  logic [cmap_pkg::CH_W-1:0]         entry_red    = '0;
  logic [cmap_pkg::CH_W-1:0]         entry_green  = '0;
  logic [cmap_pkg::CH_W-1:0]         entry_blue   = '0;
  logic signed [cmap_pkg::PIX_W-1:0] pixel        = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic [cmap_pkg::CH_W-1:0]         red;
  logic [cmap_pkg::CH_W-1:0]         green;
  logic [cmap_pkg::CH_W-1:0]         blue;
  logic                              cfg_valid    = 1'b0;
  logic                              cfg_ready;
  logic [cmap_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [cmap_pkg::PIX_W-1:0]        cfg_data     = '0;

  // shadow of the block state
  colour_t                           lut_shadow [cmap_pkg::TABLE_ENTRIES];
  logic signed [cmap_pkg::PIX_W-1:0] range_lo = cmap_pkg::RANGE_LOW_RST;
  logic signed [cmap_pkg::PIX_W-1:0] range_hi = cmap_pkg::RANGE_HIGH_RST;
  logic                              nearest  = 1'b1;

  colour_t colour_due [$];
  bit      calm;
  int      errors, quiet_cycles;
  int      n_loads, n_pixels, n_flat, n_blend, n_results, n_writes, n_settings;

  pixel_lut_colormap_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [cmap_pkg::CH_W-1:0] mix(input logic [cmap_pkg::CH_W-1:0] a,
                                                    input logic [cmap_pkg::CH_W-1:0] b,
                                                    input int unsigned f);
    int unsigned s;
    s = a * (256 - f) + b * f;
    return cmap_pkg::CH_W'(s >> 8);
  endfunction

  function automatic colour_t lut_colour(input logic signed [cmap_pkg::PIX_W-1:0] px);
    longint                     d, w, q, slot;
    int unsigned                f;
    logic [cmap_pkg::IDX_W-1:0] i;
    if (range_lo == range_hi) begin
      n_flat++;
      return (px > range_hi) ? 24'hFFFFFF : 24'h000000;
    end
    d = longint'(px) - longint'(range_lo);
    w = longint'(range_hi) - longint'(range_lo);
    q = (d * FULL_SCALE_Q) / w;
    if (nearest) begin
      slot = q / 256;
      if (slot < 0) slot = 0;
      if (slot > longint'(cmap_pkg::TABLE_ENTRIES) - 1)
        slot = longint'(cmap_pkg::TABLE_ENTRIES) - 1;
      return lut_shadow[slot];
    end
    n_blend++;
    if (q <= 0) return lut_shadow[0];
    if (q >= FULL_SCALE_Q) return lut_shadow[cmap_pkg::TOP_ENTRY];
    i = cmap_pkg::IDX_W'(q >> 8);
    f = int'(q & 255);
    return {mix(lut_shadow[i].r, lut_shadow[i + 1'b1].r, f),
            mix(lut_shadow[i].g, lut_shadow[i + 1'b1].g, f),
            mix(lut_shadow[i].b, lut_shadow[i + 1'b1].b, f)};
  endfunction

  function automatic longint clamp32(input longint v);
    if (v < PIX_MIN) return PIX_MIN;
    if (v > PIX_MAX) return PIX_MAX;
    return v;
  endfunction

  // mostly inside the configured range, some at its edges, some anywhere
  function automatic logic [cmap_pkg::PIX_W-1:0] pick_pixel();
    longint lo, hi, p;
    lo = range_lo;
    hi = range_hi;
    case ($urandom_range(9))
      7, 8:    p = ($urandom_range(1) ? hi : lo) + longint'($urandom_range(6)) - 3;
      9:       p = longint'(int'($urandom()));
      default: p = lo + ((hi - lo) * (longint'($urandom_range(1100)) - 50)) / 1000
                   + longint'($urandom_range(4)) - 2;
    endcase
    return cmap_pkg::PIX_W'(clamp32(p));
  endfunction

  task automatic send_item(input logic k, input logic [cmap_pkg::IDX_W-1:0] idx,
                           input colour_t c, input logic [cmap_pkg::PIX_W-1:0] px,
                           input logic typed, input colour_t want);
    while (!calm && $urandom_range(99) < 17) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    entry_index <= idx;
    entry_red   <= c.r;
    entry_green <= c.g;
    entry_blue  <= c.b;
    pixel       <= px;
    do @(posedge clk); while (item_stall);
    if (k == cmap_pkg::KIND_LOAD) begin
      lut_shadow[idx] = c;
      n_loads++;
    end else begin
      colour_due.push_back(typed ? want : lut_colour(px));
      n_pixels++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [cmap_pkg::CFG_IDX_W-1:0] sel,
                           input logic [cmap_pkg::PIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      cmap_pkg::REG_RANGE_LOW:  range_lo = data;
      cmap_pkg::REG_RANGE_HIGH: range_hi = data;
      cmap_pkg::REG_NEAREST:    nearest  = data[0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold items back until every colour is out, then give load items time to retire
  task automatic settle();
    item_valid <= 1'b0;
    while (colour_due.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic pick_setting();
    longint lo, hi;
    case ($urandom_range(9))
      0: begin lo = PIX_MIN; hi = PIX_MAX; end
      1: begin lo = PIX_MAX; hi = PIX_MIN; end
      2: begin lo = longint'(int'($urandom())); hi = lo; end
      3: begin
        lo = longint'($urandom_range(2000)) - 1000;
        hi = lo - longint'($urandom_range(600, 1));
      end
      4: begin lo = longint'(int'($urandom())); hi = longint'(int'($urandom())); end
      default: begin
        lo = longint'($urandom_range(2000)) - 1000;
        case ($urandom_range(2))
          0:       hi = lo + longint'($urandom_range(8, 1));
          1:       hi = lo + longint'($urandom_range(600, 9));
          default: hi = lo + longint'($urandom_range(70000, 601));
        endcase
      end
    endcase
    write_reg(cmap_pkg::REG_RANGE_LOW, cmap_pkg::PIX_W'(clamp32(lo)));
    write_reg(cmap_pkg::REG_RANGE_HIGH, cmap_pkg::PIX_W'(clamp32(hi)));
    write_reg(cmap_pkg::REG_NEAREST,
              {$urandom()} & ~32'd1 | cmap_pkg::PIX_W'($urandom_range(1)));
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom());
    n_settings++;
  endtask

  always @(negedge clk) result_stall <= !calm && ($urandom_range(99) < 17);

  always @(posedge clk) begin
    colour_t due;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (colour_due.size() == 0) begin
        report($sformatf("unexpected colour %02h %02h %02h", red, green, blue));
      end else begin
        due = colour_due.pop_front();
        if (red !== due.r) report($sformatf("red %02h, expected %02h", red, due.r));
        if (green !== due.g) report($sformatf("green %02h, expected %02h", green, due.g));
        if (blue !== due.b) report($sformatf("blue %02h, expected %02h", blue, due.b));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d colours outstanding",
               quiet_cycles, colour_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int sent, block;
    foreach (lut_shadow[k]) lut_shadow[k] = {3{cmap_pkg::CH_W'(k)}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[k]) begin
      case (PLAN[k].op)
        ROW_SETUP: begin
          settle();
          write_reg(PLAN[k].sel[cmap_pkg::CFG_IDX_W-1:0], PLAN[k].val);
        end
        ROW_LOAD:
          send_item(cmap_pkg::KIND_LOAD, PLAN[k].sel, PLAN[k].rgb, PLAN[k].val, 1'b0, '0);
        default:
          send_item(KIND_PIXEL, PLAN[k].sel, PLAN[k].rgb, PLAN[k].val, PLAN[k].typed,
                    PLAN[k].want);
      endcase
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      pick_setting();
      block = $urandom_range(150, 40);
      if (block > RANDOM_ITEMS - sent) block = RANDOM_ITEMS - sent;
      repeat (block) begin
        calm = (sent >= 700 && sent < 1000);
        send_item(($urandom_range(99) < 25) ? cmap_pkg::KIND_LOAD : KIND_PIXEL,
                  cmap_pkg::IDX_W'($urandom_range(255)), cmap_pkg::RGB_W'($urandom()),
                  pick_pixel(), 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;

    item_valid <= 1'b0;
    while (colour_due.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);

    $display("covered %0d load items and %0d pixels (%0d interpolated, %0d on an empty range)",
             n_loads, n_pixels, n_blend, n_flat);
    $display("%0d register writes over %0d random settings, %0d colours checked, %0d mismatches",
             n_writes, n_settings, n_results, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
